>>> rtl/core/lfp_pkg.sv
// Shared types and constants for the length-prefixed frame parser.
`timescale 1ns / 1ps

package lfp_pkg;

  localparam int unsigned HEADER_BYTES = 10;
  localparam int unsigned ID_POS = 2;
  localparam int unsigned CORR_POS = 6;

  localparam int unsigned COUNT_W = $clog2(HEADER_BYTES + 1);
  localparam int unsigned MAX_W = 31;
  localparam int unsigned OFFSET_W = 31;
  localparam int unsigned LEN_W = 32;

  localparam logic [COUNT_W-1:0] COUNT_ID = COUNT_W'(ID_POS);
  localparam logic [COUNT_W-1:0] COUNT_CORR = COUNT_W'(CORR_POS);
  localparam logic [COUNT_W-1:0] COUNT_LAST = COUNT_W'(HEADER_BYTES - 1);
  localparam logic [COUNT_W-1:0] COUNT_PAYLOAD = COUNT_W'(HEADER_BYTES);

  localparam logic [MAX_W-1:0] MAX_PAYLOAD_RESET = MAX_W'(1024);

  localparam logic BYTE_HEADER = 1'b0;
  localparam logic BYTE_PAYLOAD = 1'b1;

  typedef struct packed {
    logic                    byte_kind;
    logic [7:0]              byte_value;
    logic [OFFSET_W-1:0]     payload_offset;
    logic                    header_done;
    logic [15:0]             message_id;
    logic signed [LEN_W-1:0] payload_length;
    logic signed [LEN_W-1:0] correlation_id;
    logic                    frame_last;
    logic                    length_error;
  } lfp_result_t;

endpackage

>>> rtl/core/lfp_parse.sv
// Header assembly, frame state and result formation for one stream byte.
`timescale 1ns / 1ps

module lfp_parse
  import lfp_pkg::*;
(
  input  logic              clk,
  input  logic              rst,
  input  logic              take,
  input  logic [7:0]        data_byte,
  input  logic              cfg_we,
  input  logic [MAX_W-1:0]  cfg_data,
  output lfp_result_t       result
);

  logic [COUNT_W-1:0]  header_count, header_count_next;
  logic [15:0]         id_reg, id_reg_next;
  logic [LEN_W-1:0]    length_reg, length_reg_next;
  logic [LEN_W-1:0]    correlation_reg, correlation_reg_next;
  logic [OFFSET_W-1:0] payload_count, payload_count_next;
  logic [MAX_W-1:0]    max_payload;

  logic [OFFSET_W-1:0] count_inc;
  logic [1:0]          lane;
  logic                err;

  always_comb begin
    header_count_next = header_count;
    id_reg_next = id_reg;
    length_reg_next = length_reg;
    correlation_reg_next = correlation_reg;
    payload_count_next = payload_count;
    count_inc = payload_count + OFFSET_W'(1);
    lane = 2'(header_count);
    err = 1'b0;
    result = '0;
    result.byte_value = data_byte;

    if (header_count < COUNT_PAYLOAD) begin
      result.byte_kind = BYTE_HEADER;
      if (header_count < COUNT_ID) begin
        id_reg_next[lane[0]*8 +: 8] = data_byte;
      end else if (header_count < COUNT_CORR) begin
        lane = 2'(header_count - COUNT_ID);
        length_reg_next[lane*8 +: 8] = data_byte;
      end else begin
        lane = 2'(header_count - COUNT_CORR);
        correlation_reg_next[lane*8 +: 8] = data_byte;
      end
      header_count_next = header_count + COUNT_W'(1);
      if (header_count == COUNT_LAST) begin
        err = length_reg_next[LEN_W-1] ||
              (length_reg_next > {{(LEN_W-MAX_W){1'b0}}, max_payload});
        result.header_done = 1'b1;
        result.message_id = id_reg_next;
        result.payload_length = length_reg_next;
        result.correlation_id = correlation_reg_next;
        result.length_error = err;
        payload_count_next = '0;
        if (err || length_reg_next == '0) begin
          result.frame_last = 1'b1;
          header_count_next = '0;
        end
      end
    end else begin
      result.byte_kind = BYTE_PAYLOAD;
      result.payload_offset = payload_count;
      payload_count_next = count_inc;
      if ({{(LEN_W-OFFSET_W){1'b0}}, count_inc} >= length_reg) begin
        result.frame_last = 1'b1;
        header_count_next = '0;
        payload_count_next = '0;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      header_count <= '0;
      id_reg <= '0;
      length_reg <= '0;
      correlation_reg <= '0;
      payload_count <= '0;
      max_payload <= MAX_PAYLOAD_RESET;
    end else begin
      if (cfg_we) begin
        max_payload <= cfg_data;
      end
      if (take) begin
        header_count <= header_count_next;
        id_reg <= id_reg_next;
        length_reg <= length_reg_next;
        correlation_reg <= correlation_reg_next;
        payload_count <= payload_count_next;
      end
    end
  end

endmodule

>>> rtl/core/length_prefixed_frame_parser.sv
// Top level of the length-prefixed frame parser with a two-entry output buffer.
//
//   channel  direction  handshake            payload
//   in       sink       in_valid / in_stall  data_byte
//   out      source     out_valid/out_stall  byte_kind .. length_error
//   cfg      sink       cfg_valid/cfg_ready  cfg_data (max_payload)
//
// One result per input byte; while in_stall is low a byte can be accepted
// every cycle, and its result is registered in the output or skid register.
// A skid register holds one result when out_stall is high, and in_stall is
// raised only while that skid register is full.
// Synchronous reset clears frame state, buffer valid bits and sets
// max_payload to 1024. Configuration requests are always accepted.
`timescale 1ns / 1ps

module length_prefixed_frame_parser
  import lfp_pkg::*;
(
  input  logic                    clk,
  input  logic                    rst,
  input  logic                    in_valid,
  output logic                    in_stall,
  input  logic [7:0]              data_byte,
  output logic                    out_valid,
  input  logic                    out_stall,
  output logic                    byte_kind,
  output logic [7:0]              byte_value,
  output logic [OFFSET_W-1:0]     payload_offset,
  output logic                    header_done,
  output logic [15:0]             message_id,
  output logic signed [LEN_W-1:0] payload_length,
  output logic signed [LEN_W-1:0] correlation_id,
  output logic                    frame_last,
  output logic                    length_error,
  input  logic                    cfg_valid,
  output logic                    cfg_ready,
  input  logic [MAX_W-1:0]        cfg_data
);

  lfp_result_t result, out_res, skid_res;
  logic        skid_valid;
  logic        in_take, out_take;

  assign cfg_ready = 1'b1;
  assign in_stall = skid_valid;
  assign in_take = in_valid && !in_stall;
  assign out_take = out_valid && !out_stall;

  lfp_parse u_parse (
    .clk       (clk),
    .rst       (rst),
    .take      (in_take),
    .data_byte (data_byte),
    .cfg_we    (cfg_valid && cfg_ready),
    .cfg_data  (cfg_data),
    .result    (result)
  );

  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
      skid_valid <= 1'b0;
    end else if (in_take) begin
      if (!out_valid || out_take) begin
        out_res <= result;
        out_valid <= 1'b1;
      end else begin
        skid_res <= result;
        skid_valid <= 1'b1;
      end
    end else if (out_take) begin
      out_res <= skid_res;
      out_valid <= skid_valid;
      skid_valid <= 1'b0;
    end
  end

  assign byte_kind = out_res.byte_kind;
  assign byte_value = out_res.byte_value;
  assign payload_offset = out_res.payload_offset;
  assign header_done = out_res.header_done;
  assign message_id = out_res.message_id;
  assign payload_length = out_res.payload_length;
  assign correlation_id = out_res.correlation_id;
  assign frame_last = out_res.frame_last;
  assign length_error = out_res.length_error;

  a_err_ends_header : assert property (@(posedge clk) disable iff (rst)
    out_valid && length_error |-> header_done && frame_last && byte_kind == BYTE_HEADER)
    else $error("length error outside a closing header byte");

  a_open_frame_length : assert property (@(posedge clk) disable iff (rst)
    out_valid && header_done && !frame_last |-> !length_error && payload_length > 0)
    else $error("frame left open with an invalid length");

  a_skid_fill : assert property (@(posedge clk) disable iff (rst)
    in_take && out_valid && out_stall |=> skid_valid && out_valid)
    else $error("stalled result not held in skid register");

  a_skid_needs_out : assert property (@(posedge clk) disable iff (rst)
    skid_valid |-> out_valid)
    else $error("skid register full while output register empty");

endmodule

>>> bench/tb_length_prefixed_frame_parser.sv
// Self-checking testbench for the length-prefixed frame parser, fed directed and random frames.
`timescale 1ns / 1ps

module tb_length_prefixed_frame_parser;
  import lfp_pkg::*;

  localparam int unsigned QUIET_LIMIT = 2000;
  localparam int unsigned MAX_REPORTS = 40;
  localparam int unsigned PHASE_BYTES = 180;
  localparam int unsigned PHASES = 6;

  logic                    clk = 1'b0;
  logic                    rst = 1'b1;
  logic                    in_valid = 1'b0;
  logic                    in_stall;
  logic [7:0]              data_byte = 8'h00;
  logic                    out_valid;
  logic                    out_stall = 1'b0;
  logic                    byte_kind;
  logic [7:0]              byte_value;
  logic [OFFSET_W-1:0]     payload_offset;
  logic                    header_done;
  logic [15:0]             message_id;
  logic signed [LEN_W-1:0] payload_length;
  logic signed [LEN_W-1:0] correlation_id;
  logic                    frame_last;
  logic                    length_error;
  logic                    cfg_valid = 1'b0;
  logic                    cfg_ready;
  logic [MAX_W-1:0]        cfg_data = '0;

  logic [7:0]  stream_q[$];
  lfp_result_t expected_q[$];

  logic [MAX_W-1:0]    max_len_cfg = MAX_PAYLOAD_RESET;
  int unsigned         hdr_count = 0;
  logic [15:0]         id_acc = '0;
  logic [31:0]         len_acc = '0;
  logic [31:0]         corr_acc = '0;
  logic [OFFSET_W-1:0] pay_count = '0;

  bit          sender_bursty = 1'b0;
  bit          receiver_stalls = 1'b0;
  int unsigned gap_left = 0;
  int unsigned burst_left = 0;
  int unsigned stall_left = 0;
  bit          stall_run = 1'b0;
  int unsigned errors = 0;
  int unsigned quiet_cycles = 0;

  length_prefixed_frame_parser dut (
    .clk(clk),
    .rst(rst),
    .in_valid(in_valid),
    .in_stall(in_stall),
    .data_byte(data_byte),
    .out_valid(out_valid),
    .out_stall(out_stall),
    .byte_kind(byte_kind),
    .byte_value(byte_value),
    .payload_offset(payload_offset),
    .header_done(header_done),
    .message_id(message_id),
    .payload_length(payload_length),
    .correlation_id(correlation_id),
    .frame_last(frame_last),
    .length_error(length_error),
    .cfg_valid(cfg_valid),
    .cfg_ready(cfg_ready),
    .cfg_data(cfg_data)
  );

  always begin
    #5 clk = 1'b1;
    #5 clk = 1'b0;
  end

  function automatic lfp_result_t deframe_byte(input logic [7:0] b);
    lfp_result_t r;
    r = '0;
    r.byte_value = b;
    if (hdr_count < HEADER_BYTES) begin
      r.byte_kind = BYTE_HEADER;
      if (hdr_count < ID_POS) begin
        id_acc[hdr_count*8 +: 8] = b;
      end else if (hdr_count < CORR_POS) begin
        len_acc[(hdr_count-ID_POS)*8 +: 8] = b;
      end else begin
        corr_acc[(hdr_count-CORR_POS)*8 +: 8] = b;
      end
      hdr_count++;
      if (hdr_count == HEADER_BYTES) begin
        r.header_done = 1'b1;
        r.message_id = id_acc;
        r.payload_length = len_acc;
        r.correlation_id = corr_acc;
        r.length_error = len_acc[31] || (len_acc > {1'b0, max_len_cfg});
        pay_count = '0;
        if (r.length_error || len_acc == 0) begin
          r.frame_last = 1'b1;
          hdr_count = 0;
        end
      end
    end else begin
      r.byte_kind = BYTE_PAYLOAD;
      r.payload_offset = pay_count;
      pay_count = pay_count + 1'b1;
      if ({1'b0, pay_count} >= len_acc) begin
        r.frame_last = 1'b1;
        hdr_count = 0;
        pay_count = '0;
      end
    end
    return r;
  endfunction

  task automatic report(input string msg);
    if (errors < MAX_REPORTS) $display("%0t: %s", $time, msg);
    errors++;
  endtask

  task automatic check_field(input string what, input logic [63:0] got,
                             input logic [63:0] want);
    if (got !== want) report($sformatf("%s is %0h, expected %0h", what, got, want));
  endtask

  task automatic push_frame(input logic [15:0] id, input logic [31:0] len,
                            input logic [31:0] corr);
    int unsigned n;
    for (int i = 0; i < 2; i++) stream_q.push_back(id[i*8 +: 8]);
    for (int i = 0; i < 4; i++) stream_q.push_back(len[i*8 +: 8]);
    for (int i = 0; i < 4; i++) stream_q.push_back(corr[i*8 +: 8]);
    n = 0;
    if (!len[31] && len != 0 && len <= {1'b0, max_len_cfg}) n = len;
    repeat (n) stream_q.push_back(8'($urandom_range(0, 255)));
  endtask

  task automatic push_random_frame();
    int unsigned pick;
    int unsigned cap;
    logic [31:0] len;
    pick = $urandom_range(0, 99);
    cap = (max_len_cfg < 16) ? max_len_cfg : 16;
    if (pick < 55 && max_len_cfg != 0) begin
      len = $urandom_range(1, cap);
    end else if (pick < 63 && max_len_cfg != 0) begin
      len = $urandom_range(1, (max_len_cfg < 200) ? max_len_cfg : 200);
    end else if (pick < 71) begin
      len = 0;
    end else if (pick < 79) begin
      len = $urandom | 32'h8000_0000;
    end else if (pick < 89 && max_len_cfg != {MAX_W{1'b1}}) begin
      len = {1'b0, max_len_cfg} + 1;
      if ($urandom_range(0, 1) == 1)
        len = len + ($urandom % (32'h7FFF_FFFF - {1'b0, max_len_cfg}));
    end else begin
      // Fully random header; a long legal length is turned negative.
      len = $urandom;
      if (!len[31] && len <= {1'b0, max_len_cfg} && len > 256) len[31] = 1'b1;
    end
    push_frame(16'($urandom), len, $urandom);
  endtask

  task automatic wait_idle();
    while (stream_q.size() != 0 || in_valid || expected_q.size() != 0) @(posedge clk);
    repeat (3) @(posedge clk);
  endtask

  task automatic write_max(input logic [MAX_W-1:0] value);
    cfg_valid <= 1'b1;
    cfg_data <= value;
    @(posedge clk);
    while (!cfg_ready) @(posedge clk);
    cfg_valid <= 1'b0;
    max_len_cfg = value;
  endtask

  always @(posedge clk) begin : driver
    bit took;
    took = in_valid && !in_stall;
    if (rst) begin
      in_valid <= 1'b0;
    end else begin
      if (took) expected_q.push_back(deframe_byte(data_byte));
      if (!in_valid || took) begin
        if (gap_left > 0) begin
          gap_left--;
          in_valid <= 1'b0;
        end else if (stream_q.size() > 0) begin
          data_byte <= stream_q.pop_front();
          in_valid <= 1'b1;
          if (burst_left > 0) begin
            burst_left--;
          end else if (sender_bursty) begin
            gap_left = $urandom_range(1, 12);
            burst_left = $urandom_range(0, 40);
          end
        end else begin
          in_valid <= 1'b0;
        end
      end
    end
  end

  always @(posedge clk) begin : monitor
    lfp_result_t want;
    if (rst) begin
      out_stall <= 1'b0;
    end else begin
      if (out_valid && !out_stall) begin
        if (expected_q.size() == 0) begin
          report("result with no request waiting");
        end else begin
          want = expected_q.pop_front();
          check_field("byte_kind", byte_kind, want.byte_kind);
          check_field("byte_value", byte_value, want.byte_value);
          check_field("payload_offset", payload_offset, want.payload_offset);
          check_field("header_done", header_done, want.header_done);
          check_field("message_id", message_id, want.message_id);
          check_field("payload_length", payload_length, want.payload_length);
          check_field("correlation_id", correlation_id, want.correlation_id);
          check_field("frame_last", frame_last, want.frame_last);
          check_field("length_error", length_error, want.length_error);
        end
      end
      if (stall_left == 0) begin
        stall_run = ($urandom_range(0, 2) == 0);
        stall_left = $urandom_range(1, 12);
      end else begin
        stall_left--;
      end
      out_stall <= receiver_stalls && stall_run;
    end
  end

  always @(posedge clk) begin : watchdog
    if (rst || (in_valid && !in_stall) || (out_valid && !out_stall) ||
        (cfg_valid && cfg_ready)) begin
      quiet_cycles <= 0;
    end else if (quiet_cycles >= QUIET_LIMIT) begin
      $display("[FAIL] regression broken");
      $finish;
    end else begin
      quiet_cycles <= quiet_cycles + 1;
    end
  end

  initial begin : stimulus
    int unsigned start;
    for (int phase = 0; phase < PHASES; phase++) begin
      if (phase == 0) begin
        push_frame(16'hFFFF, 32'h0000_0000, 32'hFFFF_FFFF);
        push_frame(16'h0000, 32'h8000_0000, 32'h0000_0000);
        repeat (5) @(posedge clk);
        rst <= 1'b0;
      end else begin
        wait_idle();
        case (phase)
          1: write_max('0);
          2: write_max(MAX_W'(5));
          3: write_max({MAX_W{1'b1}});
          4: write_max(MAX_W'($urandom));
          default: write_max(MAX_W'(1));
        endcase
        if (phase == 2) begin
          push_frame(16'h1234, 32'd5, 32'h0BAD_F00D);
          push_frame(16'h4321, 32'd6, 32'h7FFF_FFFF);
        end
      end
      sender_bursty = (phase % 2 == 1);
      receiver_stalls = (phase % 3 != 0);
      start = stream_q.size();
      while (stream_q.size() - start < PHASE_BYTES) push_random_frame();
    end
    wait_idle();
    repeat (8) @(posedge clk);
    if (errors == 0) $display("[ OK ] regression clean");
    else $display("[FAIL] regression broken");
    $finish;
  end

endmodule

>>> filelist.f
rtl/core/lfp_pkg.sv
rtl/core/lfp_parse.sv
rtl/core/length_prefixed_frame_parser.sv
bench/tb_length_prefixed_frame_parser.sv
